### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### rtl/core/lsw_pkg.sv
`default_nettype none
package lsw_pkg;

  localparam logic [12:0] LS_FAR  = 13'd6096;
  localparam logic [12:0] LS_MID  = 13'd3658;
  localparam logic [12:0] LS_NEAR = 13'd1219;
  localparam logic [16:0] L_EXTRA = 17'd3840;
  localparam logic [13:0] RPM_SCALE = 14'd15360;

  localparam logic [1:0] SIDE_STRAIGHT = 2'd0;
  localparam logic [1:0] SIDE_ONE      = 2'd1;
  localparam logic [1:0] SIDE_TWO      = 2'd2;

  localparam logic [1:0] REG_SENSOR_DISTANCE = 2'd0;
  localparam logic [1:0] REG_WHEEL_PERIMETER = 2'd1;
  localparam logic [1:0] REG_MOTOR_SPACING   = 2'd2;
  localparam logic [1:0] REG_BASE_SPEED      = 2'd3;

  localparam logic [15:0] RST_SENSOR_DISTANCE = 16'd23040;
  localparam logic [17:0] RST_WHEEL_PERIMETER = 18'd32170;
  localparam logic [15:0] RST_MOTOR_SPACING   = 16'd25600;
  localparam logic [15:0] RST_BASE_SPEED      = 16'd0;

  typedef struct packed {
    logic [15:0] sensor_distance;
    logic [17:0] wheel_perimeter;
    logic [15:0] motor_spacing;
    logic [15:0] base_speed;
  } lsw_cfg_t;

  // Dividend per lane (lane 0 inner wheel, lane 1 outer wheel) and shared divisor.
  typedef struct packed {
    logic [1:0][63:0] num;
    logic [51:0]      den;
    logic [1:0]       side;
  } lsw_quot_t;

  typedef struct packed {
    logic [12:0] ls;
    logic [1:0]  side;
  } lsw_dec_t;

  function automatic lsw_dec_t decode_pattern(input logic [5:0] pat);
    lsw_dec_t r;
    r.ls = '0;
    r.side = SIDE_STRAIGHT;
    case (pat)
      6'h01, 6'h03: begin r.ls = LS_FAR;  r.side = SIDE_ONE; end
      6'h02, 6'h06: begin r.ls = LS_MID;  r.side = SIDE_ONE; end
      6'h04:        begin r.ls = LS_NEAR; r.side = SIDE_ONE; end
      6'h08:        begin r.ls = LS_NEAR; r.side = SIDE_TWO; end
      6'h10, 6'h18: begin r.ls = LS_MID;  r.side = SIDE_TWO; end
      6'h20, 6'h30: begin r.ls = LS_FAR;  r.side = SIDE_TWO; end
      default:      begin r.ls = '0;      r.side = SIDE_STRAIGHT; end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/line_sensor_wheel_rpm.sv
// Pipeline: 5 arithmetic stages, then a 17-stage restoring divider (a
// saturation-check stage, then one quotient bit per stage).
// Throughput: one pattern per cycle; each stage holds only while the stage
// after it is full and stalled.
// Reset: synchronous, clears all stage valid bits and loads register defaults.
`default_nettype none
module line_sensor_wheel_rpm (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [5:0]  sensor_pattern,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] left_rpm,
  output logic [15:0] right_rpm,
  output logic [1:0]  turn_side,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [17:0] cfg_data
);
  import lsw_pkg::*;

  `include "assert_macros.svh"

  lsw_cfg_t  cfg;
  lsw_quot_t fr_data;
  logic      fr_valid, fr_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_distance <= RST_SENSOR_DISTANCE;
      cfg.wheel_perimeter <= RST_WHEEL_PERIMETER;
      cfg.motor_spacing   <= RST_MOTOR_SPACING;
      cfg.base_speed      <= RST_BASE_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENSOR_DISTANCE: cfg.sensor_distance <= cfg_data[15:0];
        REG_WHEEL_PERIMETER: cfg.wheel_perimeter <= cfg_data;
        REG_MOTOR_SPACING:   cfg.motor_spacing   <= cfg_data[15:0];
        REG_BASE_SPEED:      cfg.base_speed      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lsw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sensor_pattern (sensor_pattern),
    .cfg            (cfg),
    .fr_valid       (fr_valid),
    .fr_ready       (fr_ready),
    .fr_data        (fr_data)
  );

  lsw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .dv_valid  (fr_valid),
    .dv_ready  (fr_ready),
    .dv_data   (fr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_rpm  (left_rpm),
    .right_rpm (right_rpm),
    .turn_side (turn_side)
  );

  `ASSERT_IMPLY(a_straight_equal, clk, rst, out_valid && turn_side == SIDE_STRAIGHT,
                left_rpm == right_rpm, "straight result with unequal wheels")
  `ASSERT_IMPLY(a_side_one_inner, clk, rst, out_valid && turn_side == SIDE_ONE,
                left_rpm <= right_rpm, "side one inner wheel faster than outer")
  `ASSERT_IMPLY(a_side_two_inner, clk, rst, out_valid && turn_side == SIDE_TWO,
                right_rpm <= left_rpm, "side two inner wheel faster than outer")
  `ASSERT_NEVER(a_side_code, clk, rst, out_valid && turn_side == 2'd3,
                "turn side code out of range")

endmodule
`default_nettype wire

### rtl/core/lsw_front.sv
`default_nettype none
module lsw_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [5:0]             sensor_pattern,
  input  lsw_pkg::lsw_cfg_t      cfg,
  output logic                   fr_valid,
  input  wire                    fr_ready,
  output lsw_pkg::lsw_quot_t     fr_data
);
  import lsw_pkg::*;

  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;

  logic [1:0]  side1;
  logic [12:0] ls1;
  logic [16:0] l1;

  logic [1:0]  side2;
  logic [25:0] lsq2;
  logic [33:0] lsq2_l;
  logic [28:0] d2;

  logic [1:0]  side3;
  logic [33:0] s3;
  logic [1:0][33:0] num3;
  logic [29:0] sp3;
  logic [17:0] per3;

  logic [1:0]  side4;
  logic [1:0][46:0] plo4;
  logic [1:0][46:0] phi4;
  logic [51:0] den4;

  logic [1:0]  side5;
  logic [1:0][63:0] num5;
  logic [51:0] den5;

  lsw_dec_t dec;
  logic [33:0] s_sum;
  logic [33:0] d_ext;

  assign en5 = !v5 || fr_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign dec   = decode_pattern(sensor_pattern);
  assign s_sum = {8'd0, lsq2} + lsq2_l;
  assign d_ext = {5'd0, d2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Decode and axle-to-line distance.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      side1 <= dec.side;
      ls1   <= dec.ls;
      l1    <= {1'b0, cfg.sensor_distance} + L_EXTRA;
    end
  end

  // Squares and spacing product.
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      side2  <= side1;
      lsq2   <= ls1 * ls1;
      lsq2_l <= l1 * l1;
      d2     <= cfg.motor_spacing * ls1;
    end
  end

  // Radius terms; straight runs as ratio one over one.
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      side3 <= side2;
      sp3   <= cfg.base_speed * RPM_SCALE;
      per3  <= (cfg.wheel_perimeter == '0) ? 18'd1 : cfg.wheel_perimeter;
      if (side2 == SIDE_STRAIGHT) begin
        s3      <= 34'd1;
        num3[0] <= 34'd1;
        num3[1] <= 34'd1;
      end else begin
        s3      <= s_sum;
        num3[0] <= (d_ext > s_sum) ? 34'd0 : s_sum - d_ext;
        num3[1] <= s_sum + d_ext;
      end
    end
  end

  // Divisor product, and the dividend as two partial products over the halves of the ratio numerator.
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      side4 <= side3;
      den4  <= s3 * per3;
      for (int i = 0; i < 2; i++) begin
        plo4[i] <= sp3 * num3[i][16:0];
        phi4[i] <= sp3 * num3[i][33:17];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      side5 <= side4;
      den5  <= den4;
      for (int i = 0; i < 2; i++) begin
        num5[i] <= {phi4[i], 17'd0} + {17'd0, plo4[i]};
      end
    end
  end

  assign fr_valid     = v5;
  assign fr_data.num  = num5;
  assign fr_data.den  = den5;
  assign fr_data.side = side5;

endmodule
`default_nettype wire

### rtl/core/lsw_div.sv
`default_nettype none
module lsw_div (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    dv_valid,
  output logic                   dv_ready,
  input  lsw_pkg::lsw_quot_t     dv_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [15:0]            left_rpm,
  output logic [15:0]            right_rpm,
  output logic [1:0]             turn_side
);
  import lsw_pkg::*;

  localparam int QBITS = 16;
  localparam int NS = QBITS + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [51:0]       den_q  [NS];
  logic [1:0][63:0]  rem_q  [NS];
  logic [1:0][15:0]  quo_q  [NS];
  logic [1:0]        sat_q  [NS];
  logic [1:0]        side_q [NS];

  logic [15:0] inner_rpm, outer_rpm;

  assign en[NS-1] = !v[NS-1] || out_ready;
  assign en[0]    = !v[0] || en[1];
  assign dv_ready = en[0];

  // Stage 0: flag quotients that cannot fit in 16 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && dv_valid) begin
      den_q[0]  <= dv_data.den;
      rem_q[0]  <= dv_data.num;
      quo_q[0]  <= '0;
      side_q[0] <= dv_data.side;
      for (int i = 0; i < 2; i++) begin
        sat_q[0][i] <= {4'd0, dv_data.num[i]} >= {dv_data.den, 16'd0};
      end
    end
  end

  // One restoring step per stage, MSB first.
  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int B = QBITS - k;
    logic [67:0] dsh;
    logic [1:0]  ge;
    logic [1:0][15:0] qn;

    if (k < NS - 1) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end

    assign dsh = {16'd0, den_q[k-1]} << B;
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        ge[i]    = {4'd0, rem_q[k-1][i]} >= dsh;
        qn[i]    = quo_q[k-1][i];
        qn[i][B] = ge[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && v[k-1]) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        quo_q[k]  <= qn;
        for (int i = 0; i < 2; i++) begin
          rem_q[k][i] <= ge[i] ? rem_q[k-1][i] - dsh[63:0] : rem_q[k-1][i];
        end
      end
    end
  end

  assign inner_rpm = sat_q[NS-1][0] ? 16'hFFFF : quo_q[NS-1][0];
  assign outer_rpm = sat_q[NS-1][1] ? 16'hFFFF : quo_q[NS-1][1];

  assign out_valid = v[NS-1];
  assign turn_side = side_q[NS-1];
  assign left_rpm  = (side_q[NS-1] == SIDE_TWO) ? outer_rpm : inner_rpm;
  assign right_rpm = (side_q[NS-1] == SIDE_TWO) ? inner_rpm : outer_rpm;

endmodule
`default_nettype wire

### verif/rpm_checker.sv
module rpm_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [5:0]  sensor_pattern,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [15:0] left_rpm,
  input  wire  [15:0] right_rpm,
  input  wire  [1:0]  turn_side,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [17:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsw_pkg::*;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [1:0]  side;
  } wheel_result_t;

  wheel_result_t wheel_queue[$];
  logic [15:0] axle_to_sensor;
  logic [17:0] perimeter;
  logic [15:0] spacing;
  logic [15:0] speed;

  function automatic logic [15:0] rpm_of(logic [63:0] num, logic [63:0] den);
    logic [63:0] per;
    logic [63:0] q;
    per = (perimeter == 0) ? 64'd1 : 64'(perimeter);
    q = (64'(speed) * 64'd15360 * num) / (den * per);
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic wheel_result_t predict_wheels(logic [5:0] pat);
    wheel_result_t r;
    logic [63:0] offset, len, s, d;
    logic [15:0] inner, outer;
    offset = 0;
    r.side = SIDE_STRAIGHT;
    case (pat)
      6'h01, 6'h03: begin offset = 6096; r.side = SIDE_ONE; end
      6'h02, 6'h06: begin offset = 3658; r.side = SIDE_ONE; end
      6'h04:        begin offset = 1219; r.side = SIDE_ONE; end
      6'h08:        begin offset = 1219; r.side = SIDE_TWO; end
      6'h10, 6'h18: begin offset = 3658; r.side = SIDE_TWO; end
      6'h20, 6'h30: begin offset = 6096; r.side = SIDE_TWO; end
      default: ;
    endcase
    if (r.side == SIDE_STRAIGHT) begin
      r.left = rpm_of(1, 1);
      r.right = r.left;
    end else begin
      len = 64'(axle_to_sensor) + 64'd3840;
      s = offset * offset + len * len;
      d = 64'(spacing) * offset;
      inner = (d > s) ? 16'd0 : rpm_of(s - d, s);
      outer = rpm_of(s + d, s);
      r.left = (r.side == SIDE_ONE) ? inner : outer;
      r.right = (r.side == SIDE_ONE) ? outer : inner;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    wheel_result_t exp_r;
    if (rst) begin
      axle_to_sensor <= RST_SENSOR_DISTANCE;
      perimeter <= RST_WHEEL_PERIMETER;
      spacing <= RST_MOTOR_SPACING;
      speed <= RST_BASE_SPEED;
      wheel_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSOR_DISTANCE: axle_to_sensor <= cfg_data[15:0];
          REG_WHEEL_PERIMETER: perimeter <= cfg_data;
          REG_MOTOR_SPACING:   spacing <= cfg_data[15:0];
          REG_BASE_SPEED:      speed <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) wheel_queue.push_back(predict_wheels(sensor_pattern));
      if (out_valid && out_ready) begin
        if (wheel_queue.size() == 0) begin
          $error("unexpected result transfer");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = wheel_queue.pop_front();
          if (exp_r.left !== left_rpm || exp_r.right !== right_rpm ||
              exp_r.side !== turn_side) fail_count <= fail_count + 1;
          if (exp_r.left !== left_rpm)
            $error("left_rpm expected %0d actual %0d", exp_r.left, left_rpm);
          if (exp_r.right !== right_rpm)
            $error("right_rpm expected %0d actual %0d", exp_r.right, right_rpm);
          if (exp_r.side !== turn_side)
            $error("turn_side expected %0d actual %0d", exp_r.side, turn_side);
        end
      end
    end
  end

  assign pending = wheel_queue.size();
endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsw_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [5:0] sensor_pattern = 0;
  logic [1:0] cfg_index = 0;
  logic [17:0] cfg_data = 0;
  wire in_ready, out_valid, cfg_ready;
  wire [15:0] left_rpm, right_rpm;
  wire [1:0] turn_side;
  int fail_count, pending;
  int cycle_count = 0;
  bit busy_sink = 1;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  line_sensor_wheel_rpm dut (.*);
  rpm_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stall the result side about a quarter of the time, except in quiet stretches
  always @(posedge clk) out_ready <= busy_sink ? ($urandom_range(99) >= 26) : 1'b1;

  // hold valid after the transfer; the caller drops it once the writes are done
  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // valid stays high into the next transfer unless a gap drops it
  task automatic send_pattern(logic [5:0] pat, bit gaps);
    if (gaps) while ($urandom_range(99) < 26) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sensor_pattern <= pat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_pattern;
    logic [5:0] turns[12] = '{6'h01, 6'h03, 6'h02, 6'h06, 6'h04, 6'h08,
                              6'h10, 6'h18, 6'h20, 6'h30, 6'h0C, 6'h00};
    return ($urandom_range(99) < 70) ? turns[$urandom_range(11)] : 6'($urandom);
  endfunction

  initial begin
    logic [17:0] speeds[4] = '{18'd0, 18'd1000, 18'd65535, 18'd300};
    logic [17:0] pers[4] = '{18'd32170, 18'd1, 18'd262143, 18'd0};
    logic [17:0] dists[4] = '{18'd23040, 18'd0, 18'd65535, 18'd5000};
    logic [17:0] spaces[4] = '{18'd25600, 18'd65535, 18'd0, 18'd40000};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: a spread of patterns in each of a few setups, incl. an inner wheel clamped to zero
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_BASE_SPEED, speeds[ph]);
      write_reg(REG_WHEEL_PERIMETER, pers[ph]);
      write_reg(REG_SENSOR_DISTANCE, dists[ph]);
      write_reg(REG_MOTOR_SPACING, spaces[ph]);
      cfg_valid <= 0;
      for (int p = 0; p < 12; p++) send_pattern(6'(ph * 12 + p + ph), ph[0]);
      if (ph == 3) for (int p = 48; p < 64; p++) send_pattern(6'(p), 1);
      drain();
    end
    for (int ph = 0; ph < 10; ph++) begin
      busy_sink = (ph != 4);
      write_reg(REG_BASE_SPEED, $urandom_range(3) == 0 ? 18'd65535 : 18'($urandom_range(3000)));
      write_reg(REG_WHEEL_PERIMETER, $urandom_range(4) == 0 ? 18'($urandom_range(3)) : 18'($urandom));
      write_reg(REG_SENSOR_DISTANCE, 18'($urandom_range(65535)));
      write_reg(REG_MOTOR_SPACING, 18'($urandom_range(65535)));
      cfg_valid <= 0;
      for (int i = 0; i < 50; i++) send_pattern(pick_pattern(), ph != 4);
      drain();
    end
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
